@@ rtl/core/srrip_pkg.sv @@
// ----------------------------------------------------------------------------
// srrip_pkg
// Shared types and constants for the signature RRIP replacement block.
// ----------------------------------------------------------------------------
package srrip_pkg;

  localparam logic [1:0] RRPV_TOP  = 2'd3;
  localparam logic [1:0] CTR_TOP   = 2'd3;
  localparam int         HASH_SH1  = 12;
  localparam int         HASH_SH2  = 20;

  localparam logic       MODE_VICTIM = 1'b0;
  localparam logic       MODE_UPDATE = 1'b1;

  localparam logic       REG_HOT  = 1'b0;
  localparam logic       REG_COLD = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] set;
    logic [4:0]  way;
    logic [15:0] sig;
    logic        hit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] hot;
    logic [1:0] cold;
  } cfg_t;

endpackage

@@ rtl/core/srrip_ram.sv @@
// ----------------------------------------------------------------------------
// srrip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/srrip_front.sv @@
// ----------------------------------------------------------------------------
// srrip_front
// Accepts requests, reduces set, way and PC signature to table range.
// ----------------------------------------------------------------------------
module srrip_front import srrip_pkg::*; #(
  parameter int NUM_SETS    = 2048,
  parameter int NUM_WAYS    = 16,
  parameter int SIG_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [10:0] in_set_index,
  input  logic [3:0]  in_way_index,
  input  logic [63:0] in_program_counter,
  input  logic        in_was_hit,
  input  logic        clearing,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data
);

  localparam bit SETS_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
  localparam bit SIG_POW2  = (SIG_ENTRIES & (SIG_ENTRIES - 1)) == 0;
  localparam bit NEED_ITER = !SETS_POW2 || !SIG_POW2;
  localparam int BPS       = 4;
  localparam int STEPS     = 64 / BPS;
  localparam int CNTW      = $clog2(STEPS);
  localparam int REMW      = 18;

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_SET  = 2'd1;
  localparam logic [1:0] FS_SIG  = 2'd2;
  localparam logic [1:0] FS_PUSH = 2'd3;

  logic [1:0]      fs_r, fs_nxt;
  cmd_t            cmd_r, cmd_nxt, cmd_in;
  logic [63:0]     hash_r, hash_nxt, hash;
  logic [63:0]     div_r, div_nxt, d_step;
  logic [REMW-1:0] rem_r, rem_nxt, r_step, divisor;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            accept;

  function automatic logic [4:0] way_mod(input logic [3:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 3; i >= 0; i--) begin
      r = {r[4:0], w[i]};
      if (r >= 6'(NUM_WAYS)) r = r - 6'(NUM_WAYS);
    end
    return r[4:0];
  endfunction

  assign in_stall = (fs_r != FS_IDLE) || q_full || clearing;
  assign accept   = in_valid && !in_stall;
  assign hash     = in_program_counter ^ (in_program_counter >> HASH_SH1)
                  ^ (in_program_counter >> HASH_SH2);

  always_comb begin
    cmd_in.mode = in_mode;
    cmd_in.set  = SETS_POW2 ? (16'(in_set_index) & 16'(NUM_SETS - 1))
                            : 16'(in_set_index);
    cmd_in.way  = way_mod(in_way_index);
    cmd_in.sig  = SIG_POW2 ? (hash[15:0] & 16'(SIG_ENTRIES - 1)) : 16'd0;
    cmd_in.hit  = in_was_hit;

    divisor = (fs_r == FS_SET) ? REMW'(NUM_SETS) : REMW'(SIG_ENTRIES);
    r_step  = rem_r;
    d_step  = div_r;
    for (int k = 0; k < BPS; k++) begin
      r_step = {r_step[REMW-2:0], d_step[63]};
      d_step = {d_step[62:0], 1'b0};
      if (r_step >= divisor) r_step = r_step - divisor;
    end

    fs_nxt   = fs_r;
    cmd_nxt  = cmd_r;
    hash_nxt = hash_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    q_push   = 1'b0;
    q_data   = cmd_r;

    unique case (fs_r)
      FS_IDLE: begin
        if (accept) begin
          if (!NEED_ITER) begin
            q_push = 1'b1;
            q_data = cmd_in;
          end else begin
            cmd_nxt  = cmd_in;
            hash_nxt = hash;
            rem_nxt  = '0;
            cnt_nxt  = '0;
            if (!SETS_POW2) begin
              fs_nxt  = FS_SET;
              div_nxt = 64'(in_set_index);
            end else begin
              fs_nxt  = FS_SIG;
              div_nxt = hash;
            end
          end
        end
      end
      FS_SET: begin
        rem_nxt = r_step;
        div_nxt = d_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(STEPS - 1)) begin
          cmd_nxt.set = 16'(r_step);
          rem_nxt     = '0;
          if (!SIG_POW2) begin
            fs_nxt  = FS_SIG;
            div_nxt = hash_r;
          end else begin
            fs_nxt = FS_PUSH;
          end
        end
      end
      FS_SIG: begin
        rem_nxt = r_step;
        div_nxt = d_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(STEPS - 1)) begin
          cmd_nxt.sig = 16'(r_step);
          fs_nxt      = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          fs_nxt = FS_IDLE;
        end
      end
      default: fs_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_IDLE;
    end else begin
      fs_r <= fs_nxt;
    end
    cmd_r  <= cmd_nxt;
    hash_r <= hash_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

@@ rtl/core/srrip_queue.sv @@
// ----------------------------------------------------------------------------
// srrip_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module srrip_queue import srrip_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output logic valid,
  output logic full,
  output cmd_t rdata
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign valid = cnt_r != 2'd0;
  assign full  = cnt_r == 2'd2;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

@@ rtl/core/srrip_back.sv @@
// ----------------------------------------------------------------------------
// srrip_back
// Executes victim and update requests against set and counter memories.
// ----------------------------------------------------------------------------
module srrip_back import srrip_pkg::*; #(
  parameter int NUM_SETS    = 2048,
  parameter int NUM_WAYS    = 16,
  parameter int SIG_ENTRIES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  input  cfg_t       cfg,
  output logic       clearing,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_victim_way
);

  localparam int SETW  = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
  localparam int WAYW  = $clog2(NUM_WAYS);
  localparam int SIGW  = $clog2(SIG_ENTRIES);
  localparam int LW    = 3 + SIGW;
  localparam int RW    = NUM_WAYS * LW;
  localparam int CLR_N = NUM_SETS > SIG_ENTRIES ? NUM_SETS : SIG_ENTRIES;
  localparam int CIW   = $clog2(CLR_N);
  localparam logic [RW-1:0] INIT_ROW = {NUM_WAYS{{RRPV_TOP, 1'b0, {SIGW{1'b0}}}}};

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_ROW     = 2'd1;
  localparam logic [1:0] ST_CTR_OLD = 2'd2;
  localparam logic [1:0] ST_CTR_NEW = 2'd3;

  logic [1:0]      state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [SIGW-1:0] old_sig_r, old_sig_nxt;
  logic            reuse_r, reuse_nxt;
  logic [1:0]      ctr_upd_r, ctr_upd_nxt;
  logic            clear_r, clear_nxt;
  logic [CIW-1:0]  clr_r, clr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [3:0]      out_way_r, out_way_nxt;

  logic            row_we;
  logic [SETW-1:0] row_waddr, row_raddr;
  logic [RW-1:0]   row_wdata, row_rdata, row_tmp;
  logic            ctr_we;
  logic [SIGW-1:0] ctr_waddr, ctr_raddr;
  logic [1:0]      ctr_wdata, ctr_rdata, ctr_val;

  logic [WAYW-1:0] way, vic;
  logic [LW-1:0]   cur;
  logic            any3, any2, any1;
  logic [1:0]      delta, rr, aged;

  srrip_ram #(.WIDTH(RW), .DEPTH(NUM_SETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  srrip_ram #(.WIDTH(2), .DEPTH(SIG_ENTRIES)) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  assign clearing       = clear_r;
  assign out_valid      = out_valid_r;
  assign out_victim_way = out_way_r;
  assign way            = cmd_r.way[WAYW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    old_sig_nxt   = old_sig_r;
    reuse_nxt     = reuse_r;
    ctr_upd_nxt   = ctr_upd_r;
    clear_nxt     = clear_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_way_nxt   = out_way_r;
    q_pop         = 1'b0;
    row_we        = 1'b0;
    row_waddr     = cmd_r.set[SETW-1:0];
    row_wdata     = row_r;
    row_raddr     = cmd_r.set[SETW-1:0];
    ctr_we        = 1'b0;
    ctr_waddr     = old_sig_r;
    ctr_wdata     = ctr_rdata;
    ctr_raddr     = old_sig_r;
    row_tmp       = row_rdata;
    cur           = row_rdata[way*LW +: LW];
    any3          = 1'b0;
    any2          = 1'b0;
    any1          = 1'b0;
    delta         = 2'd0;
    aged          = 2'd0;
    vic           = '0;
    rr            = 2'd0;
    ctr_val       = ctr_rdata;

    unique case (state_r)
      ST_IDLE: begin
        if (clear_r) begin
          row_we    = {1'b0, clr_r} < (CIW + 1)'(NUM_SETS);
          row_waddr = clr_r[SETW-1:0];
          row_wdata = INIT_ROW;
          ctr_we    = {1'b0, clr_r} < (CIW + 1)'(SIG_ENTRIES);
          ctr_waddr = clr_r[SIGW-1:0];
          ctr_wdata = 2'd0;
          clr_nxt   = clr_r + 1'b1;
          if (clr_r == CIW'(CLR_N - 1)) clear_nxt = 1'b0;
        end else if (q_valid && (!out_valid_r || !out_stall)) begin
          q_pop     = 1'b1;
          row_raddr = q_head.set[SETW-1:0];
          cmd_nxt   = q_head;
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        row_nxt     = row_rdata;
        old_sig_nxt = cur[SIGW-1:0];
        reuse_nxt   = cur[SIGW];
        if (cmd_r.mode == MODE_VICTIM) begin
          for (int w = 0; w < NUM_WAYS; w++) begin
            any3 |= row_rdata[w*LW + LW - 2 +: 2] == 2'd3;
            any2 |= row_rdata[w*LW + LW - 2 +: 2] == 2'd2;
            any1 |= row_rdata[w*LW + LW - 2 +: 2] == 2'd1;
          end
          delta = any3 ? 2'd0 : any2 ? 2'd1 : any1 ? 2'd2 : 2'd3;
          for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            aged = row_rdata[w*LW + LW - 2 +: 2] + delta;
            row_tmp[w*LW + LW - 2 +: 2] = aged;
            if (aged == RRPV_TOP) vic = WAYW'(w);
          end
          row_we        = delta != 2'd0;
          row_wdata     = row_tmp;
          out_valid_nxt = 1'b1;
          out_way_nxt   = 4'(vic);
          state_nxt     = ST_IDLE;
        end else begin
          ctr_raddr = cur[SIGW-1:0];
          if (cmd_r.hit) begin
            row_tmp[way*LW +: LW] = {2'd0, 1'b1, cur[SIGW-1:0]};
            row_we    = 1'b1;
            row_wdata = row_tmp;
          end
          state_nxt = ST_CTR_OLD;
        end
      end
      ST_CTR_OLD: begin
        ctr_we = 1'b1;
        if (cmd_r.hit || reuse_r) begin
          ctr_wdata = (ctr_rdata == CTR_TOP) ? ctr_rdata : ctr_rdata + 2'd1;
        end else begin
          ctr_wdata = (ctr_rdata == 2'd0) ? ctr_rdata : ctr_rdata - 2'd1;
        end
        if (cmd_r.hit) begin
          out_valid_nxt = 1'b1;
          out_way_nxt   = 4'd0;
          state_nxt     = ST_IDLE;
        end else begin
          ctr_upd_nxt = ctr_wdata;
          ctr_raddr   = cmd_r.sig[SIGW-1:0];
          state_nxt   = ST_CTR_NEW;
        end
      end
      ST_CTR_NEW: begin
        ctr_val = (cmd_r.sig[SIGW-1:0] == old_sig_r) ? ctr_upd_r : ctr_rdata;
        rr      = (ctr_val >= cfg.hot) ? 2'd0 : cfg.cold;
        row_tmp = row_r;
        row_tmp[way*LW +: LW] = {rr, 1'b0, cmd_r.sig[SIGW-1:0]};
        row_we        = 1'b1;
        row_wdata     = row_tmp;
        out_valid_nxt = 1'b1;
        out_way_nxt   = 4'd0;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clear_r     <= 1'b1;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clear_r     <= clear_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    row_r     <= row_nxt;
    old_sig_r <= old_sig_nxt;
    reuse_r   <= reuse_nxt;
    ctr_upd_r <= ctr_upd_nxt;
    out_way_r <= out_way_nxt;
  end

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> state_r == ST_IDLE)
    else $error("clearing pass overlaps a request");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE && !clear_r && q_valid)
    else $error("queue popped while busy");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !clear_r |-> !(row_we && ctr_we))
    else $error("row and counter written together");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result pending while request runs");

endmodule

@@ rtl/core/signature_rrip_replacement.sv @@
// ----------------------------------------------------------------------------
// signature_rrip_replacement
// Signature-based RRIP replacement policy with per-signature reuse counters.
//
//   channel  direction  ports
//   in_      input      in_valid/in_stall, mode, set, way, pc, hit
//   out_     output     out_valid/out_stall, victim_way
//   apb      config     psel/penable/pwrite/paddr/pwdata/prdata/pready
//
// Back part: a victim reads and ages the row; an update writes the old counter
// and a miss fill reads the new one (one row read, counter reads). Front part:
// direct if NUM_SETS and SIG_ENTRIES are powers of two, else the remainder
// unit (4 bits per cycle). After reset all rows and counters are cleared with
// in_stall high. Two requests queue between front and back; a result held by
// out_stall blocks only the start of the next request in the back.
// ----------------------------------------------------------------------------
module signature_rrip_replacement import srrip_pkg::*; #(
  parameter int NUM_SETS    = 2048,
  parameter int NUM_WAYS    = 16,
  parameter int SIG_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [10:0] in_set_index,
  input  logic [3:0]  in_way_index,
  input  logic [63:0] in_program_counter,
  input  logic        in_was_hit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_victim_way,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_r, cfg_nxt;
  logic clearing, q_full, q_push, q_pop, q_valid;
  cmd_t q_wdata, q_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COLD) ? {30'd0, cfg_r.cold} : {30'd0, cfg_r.hot};

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_HOT:  cfg_nxt.hot  = pwdata[1:0];
        REG_COLD: cfg_nxt.cold = pwdata[1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{hot: 2'd2, cold: 2'd2};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  srrip_front #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .SIG_ENTRIES (SIG_ENTRIES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_set_index       (in_set_index),
    .in_way_index       (in_way_index),
    .in_program_counter (in_program_counter),
    .in_was_hit         (in_was_hit),
    .clearing           (clearing),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_wdata)
  );

  srrip_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .valid (q_valid),
    .full  (q_full),
    .rdata (q_head)
  );

  srrip_back #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .SIG_ENTRIES (SIG_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .cfg            (cfg_r),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_victim_way (out_victim_way)
  );

endmodule
